@@ sv/psdm_pkg.sv @@
// shared constants, codes and command/status structs for the pulse speed/distance meter
// used by every other file of the block; depends on nothing
package psdm_pkg;

    localparam int RING_DEPTH = 10;
    localparam int RIDX_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RCNT_W     = $clog2(RING_DEPTH + 1);

    localparam int KIND_W  = 3;
    localparam int TS_W    = 32;
    localparam int PULL_W  = 2;
    localparam int RKIND_W = 2;
    localparam int SPD_W   = 16;
    localparam int DIST_W  = 32;
    localparam int TOT_W   = 24;

    localparam int CAL_W   = 15;
    localparam int CAL22_W = 20;
    localparam int TMO_W   = 32;
    localparam int PER_W   = 21;
    localparam int SUM_W   = 40;
    localparam int CNT_W   = 16;
    localparam int PEND_W  = 16;
    localparam int RSUM_W  = PER_W + RCNT_W;
    localparam int DIV_W   = 48;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CAL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 2'd3;

    localparam logic [CAL_W-1:0]   CAL_RST     = 15'd1000;
    localparam logic [CAL22_W-1:0] CAL22_RST   = 20'd22000;
    localparam logic [TMO_W-1:0]   TIMEOUT_RST = 32'd1000000;
    localparam logic [PER_W-1:0]   MIN_RST     = 21'd100;
    localparam logic [PER_W-1:0]   MAX_RST     = 21'd2000000;

    localparam logic [KIND_W-1:0] KIND_PULSE     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TICK      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PULL      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DRV_START = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DRV_STOP  = 3'd4;

    localparam logic [PULL_W-1:0] PULL_READY   = 2'd0;
    localparam logic [PULL_W-1:0] PULL_STAGED  = 2'd1;
    localparam logic [PULL_W-1:0] PULL_PULLING = 2'd2;

    localparam logic [RKIND_W-1:0] REP_UPDATE  = 2'd0;
    localparam logic [RKIND_W-1:0] REP_COUNT   = 2'd1;
    localparam logic [RKIND_W-1:0] REP_CAPTURE = 2'd2;

    localparam logic [DIV_W-1:0]  SPEED_NUM      = 48'd1152000000000;
    localparam logic [DIV_W-1:0]  DIST_NUM       = 48'd76800;
    localparam logic [CAL22_W-1:0] SPEED_DEN_K   = 20'd22;
    localparam logic [SUM_W-1:0]  PER_LO_FACTOR  = 40'd100;
    localparam logic [SUM_W-1:0]  PER_HI_FACTOR  = 40'd2000000;
    localparam logic [SPD_W-1:0]  SPEED_MIN_DECAY = 16'd3;
    localparam logic [TOT_W-1:0]  CAP_LO         = 24'd250;
    localparam logic [TOT_W-1:0]  CAP_HI         = 24'd25000;

    typedef struct packed {
        logic               latch;
        logic               pulse_upd;
        logic               pull_upd;
        logic               drv_start;
        logic               drv_stop;
        logic               tick_take;
        logic               dist_add;
        logic               div_period;
        logic               ring_push;
        logic               mul_load;
        logic               div_speed;
        logic               speed_load;
        logic               speed_zero;
        logic               stage_clear;
        logic               div_dist;
        logic               dist_load;
        logic               dist_special;
        logic               emit;
        logic [RKIND_W-1:0] rep_kind;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              pulses_zero;
        logic              range_ok;
        logic              drive_off;
        logic              pull_active;
        logic              staged;
        logic              timeout_hit;
        logic              cal_zero;
        logic              div_done;
        logic              out_free;
    } status_t;

endpackage

@@ sv/psdm_if.sv @@
// valid/ready channel interfaces for event beats in and report beats out
// depends on psdm_pkg
interface psdm_evt_if;
    logic                         valid;
    logic                         ready;
    logic [psdm_pkg::KIND_W-1:0]  kind;
    logic [psdm_pkg::TS_W-1:0]    timestamp_us;
    logic [psdm_pkg::PULL_W-1:0]  new_pull_state;

    modport source (output valid, kind, timestamp_us, new_pull_state, input ready);
    modport sink (input valid, kind, timestamp_us, new_pull_state, output ready);
endinterface

interface psdm_rpt_if;
    logic                         valid;
    logic                         ready;
    logic [psdm_pkg::RKIND_W-1:0] report_kind;
    logic [psdm_pkg::SPD_W-1:0]   speed_mph_q8;
    logic [psdm_pkg::DIST_W-1:0]  distance_ft_q8;
    logic [psdm_pkg::TOT_W-1:0]   pulse_total;
    logic                         capture_ok;

    modport source (output valid, report_kind, speed_mph_q8, distance_ft_q8, pulse_total,
                    capture_ok, input ready);
    modport sink (input valid, report_kind, speed_mph_q8, distance_ft_q8, pulse_total,
                  capture_ok, output ready);
endinterface

@@ sv/psdm_div.sv @@
// shared restoring divider, one quotient bit per cycle
// depends on psdm_pkg
module psdm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [psdm_pkg::DIV_W-1:0] num,
    input  logic [psdm_pkg::DIV_W-1:0] den,
    output logic                       busy,
    output logic                       done,
    output logic [psdm_pkg::DIV_W-1:0] quot
);
    localparam int W   = psdm_pkg::DIV_W;
    localparam int CW  = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic [W:0]    rem_sh;
    logic          fits;

    always_comb
    begin
        rem_sh    = {rem_reg[W-1:0], quo_reg[W-1]};
        fits      = (rem_sh >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quo_reg;

endmodule

@@ sv/psdm_dp.sv @@
// datapath: configuration, measurement state, period ring, divider operands, report register
// depends on psdm_pkg and psdm_div
module psdm_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [psdm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psdm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [psdm_pkg::KIND_W-1:0]     in_kind,
    input  logic [psdm_pkg::TS_W-1:0]       in_ts,
    input  logic [psdm_pkg::PULL_W-1:0]     in_pull,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [psdm_pkg::RKIND_W-1:0]    out_kind,
    output logic [psdm_pkg::SPD_W-1:0]      out_speed,
    output logic [psdm_pkg::DIST_W-1:0]     out_dist,
    output logic [psdm_pkg::TOT_W-1:0]      out_total,
    output logic                            out_ok,
    input  psdm_pkg::cmd_t                  cmd,
    output psdm_pkg::status_t               status
);
    localparam int RD = psdm_pkg::RING_DEPTH;

    // configuration
    logic [psdm_pkg::CAL_W-1:0]   cal_reg;
    logic [psdm_pkg::CAL22_W-1:0] cal22_reg;
    logic [psdm_pkg::TMO_W-1:0]   timeout_reg;
    logic [psdm_pkg::PER_W-1:0]   min_reg;
    logic [psdm_pkg::PER_W-1:0]   max_reg;

    // latched event
    logic [psdm_pkg::KIND_W-1:0]  kind_reg;
    logic [psdm_pkg::TS_W-1:0]    ts_reg;
    logic [psdm_pkg::PULL_W-1:0]  nps_reg;

    // measurement state
    logic                          seen_reg, seen_next;
    logic [psdm_pkg::TS_W-1:0]     last_reg, last_next;
    logic [psdm_pkg::SUM_W-1:0]    isum_reg, isum_next;
    logic [psdm_pkg::CNT_W-1:0]    icnt_reg, icnt_next;
    logic [psdm_pkg::PEND_W-1:0]   pend_reg, pend_next;
    logic [psdm_pkg::PER_W-1:0]    ring_reg [RD];
    logic [psdm_pkg::RIDX_W-1:0]   ridx_reg, ridx_next;
    logic                          rfull_reg, rfull_next;
    logic [psdm_pkg::RSUM_W-1:0]   rsum_reg, rsum_next;
    logic [psdm_pkg::TOT_W-1:0]    dpul_reg, dpul_next;
    logic [psdm_pkg::SPD_W-1:0]    speed_reg, speed_next;
    logic [psdm_pkg::PULL_W-1:0]   pull_reg, pull_next;
    logic                          drv_reg, drv_next;

    // tick snapshot and arithmetic results
    logic [psdm_pkg::PEND_W-1:0]   snap_pend_reg;
    logic [psdm_pkg::SUM_W-1:0]    snap_sum_reg;
    logic [psdm_pkg::CNT_W-1:0]    snap_cnt_reg;
    logic [psdm_pkg::DIV_W-1:0]    mul_reg;
    logic [psdm_pkg::DIST_W-1:0]   distq_reg;

    // report register
    logic                          ov_reg, ov_next;
    logic [psdm_pkg::RKIND_W-1:0]  ok_kind_reg;
    logic [psdm_pkg::SPD_W-1:0]    o_speed_reg;
    logic [psdm_pkg::DIST_W-1:0]   o_dist_reg;
    logic [psdm_pkg::TOT_W-1:0]    o_tot_reg;
    logic                          o_ok_reg;

    logic [psdm_pkg::TS_W-1:0]     elapsed;
    logic                          iv_ok;
    logic [psdm_pkg::SUM_W-1:0]    lo_lim, hi_lim;
    logic [psdm_pkg::TOT_W:0]      dsum;
    logic [psdm_pkg::TOT_W-1:0]    dsum_sat;
    logic [psdm_pkg::PER_W-1:0]    period;
    logic [psdm_pkg::RCNT_W-1:0]   n_valid;
    logic                          div_start, div_busy, div_done;
    logic [psdm_pkg::DIV_W-1:0]    div_num, div_den, div_quot;

    assign elapsed = ts_reg - last_reg;
    assign iv_ok   = (elapsed >= psdm_pkg::TS_W'(min_reg)) &&
                     (elapsed <= psdm_pkg::TS_W'(max_reg)) && (icnt_reg != '1);
    assign lo_lim  = psdm_pkg::SUM_W'(snap_cnt_reg) * psdm_pkg::PER_LO_FACTOR;
    assign hi_lim  = psdm_pkg::SUM_W'(snap_cnt_reg) * psdm_pkg::PER_HI_FACTOR;
    assign dsum    = {1'b0, dpul_reg} + (psdm_pkg::TOT_W + 1)'(snap_pend_reg);
    assign dsum_sat = dsum[psdm_pkg::TOT_W] ? '1 : dsum[psdm_pkg::TOT_W-1:0];
    assign period  = div_quot[psdm_pkg::PER_W-1:0];
    assign n_valid = rfull_reg ? psdm_pkg::RCNT_W'(RD) : psdm_pkg::RCNT_W'(ridx_reg);

    // divider operand select
    assign div_start = cmd.div_period | cmd.div_speed | cmd.div_dist;
    always_comb
    begin
        if (cmd.div_period)
        begin
            div_num = psdm_pkg::DIV_W'(snap_sum_reg);
            div_den = psdm_pkg::DIV_W'(snap_cnt_reg);
        end
        else if (cmd.div_speed)
        begin
            div_num = psdm_pkg::SPEED_NUM * psdm_pkg::DIV_W'(n_valid);
            div_den = mul_reg;
        end
        else
        begin
            div_num = psdm_pkg::DIST_NUM * psdm_pkg::DIV_W'(dpul_reg);
            div_den = psdm_pkg::DIV_W'(cal_reg);
        end
    end

    psdm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        seen_next  = seen_reg;
        last_next  = last_reg;
        isum_next  = isum_reg;
        icnt_next  = icnt_reg;
        pend_next  = pend_reg;
        ridx_next  = ridx_reg;
        rfull_next = rfull_reg;
        rsum_next  = rsum_reg;
        dpul_next  = dpul_reg;
        speed_next = speed_reg;
        pull_next  = pull_reg;
        drv_next   = drv_reg;

        if (cmd.pulse_upd)
        begin
            if (seen_reg && iv_ok)
            begin
                isum_next = isum_reg + psdm_pkg::SUM_W'(elapsed);
                icnt_next = icnt_reg + psdm_pkg::CNT_W'(1);
            end
            last_next = ts_reg;
            seen_next = 1'b1;
            if (pend_reg != '1)
                pend_next = pend_reg + psdm_pkg::PEND_W'(1);
        end
        if (cmd.tick_take)
        begin
            isum_next = '0;
            icnt_next = '0;
            pend_next = '0;
        end
        if (cmd.pull_upd)
        begin
            pull_next = nps_reg;
            if (nps_reg == psdm_pkg::PULL_STAGED)
                dpul_next = '0;
        end
        if (cmd.drv_start)
        begin
            drv_next  = 1'b1;
            dpul_next = '0;
        end
        if (cmd.drv_stop)
            drv_next = 1'b0;
        if (cmd.dist_add)
            dpul_next = dsum_sat;
        if (cmd.stage_clear)
            dpul_next = '0;
        if (cmd.ring_push)
        begin
            rsum_next = rsum_reg - psdm_pkg::RSUM_W'(ring_reg[ridx_reg])
                        + psdm_pkg::RSUM_W'(period);
            if (ridx_reg == psdm_pkg::RIDX_W'(RD - 1))
            begin
                ridx_next  = '0;
                rfull_next = 1'b1;
            end
            else
                ridx_next = ridx_reg + psdm_pkg::RIDX_W'(1);
        end
        if (cmd.speed_load)
            speed_next = (div_quot > psdm_pkg::DIV_W'({psdm_pkg::SPD_W{1'b1}})) ? '1
                         : div_quot[psdm_pkg::SPD_W-1:0];
        if (cmd.speed_zero)
            speed_next = '0;
    end

    assign ov_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : ov_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg     <= psdm_pkg::CAL_RST;
            cal22_reg   <= psdm_pkg::CAL22_RST;
            timeout_reg <= psdm_pkg::TIMEOUT_RST;
            min_reg     <= psdm_pkg::MIN_RST;
            max_reg     <= psdm_pkg::MAX_RST;
            seen_reg    <= 1'b0;
            last_reg    <= '0;
            isum_reg    <= '0;
            icnt_reg    <= '0;
            pend_reg    <= '0;
            for (int i = 0; i < RD; i++)
                ring_reg[i] <= '0;
            ridx_reg    <= '0;
            rfull_reg   <= 1'b0;
            rsum_reg    <= '0;
            dpul_reg    <= '0;
            speed_reg   <= '0;
            pull_reg    <= psdm_pkg::PULL_READY;
            drv_reg     <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    psdm_pkg::CFG_CAL:
                    begin
                        cal_reg   <= cfg_data[psdm_pkg::CAL_W-1:0];
                        cal22_reg <= psdm_pkg::CAL22_W'(cfg_data[psdm_pkg::CAL_W-1:0])
                                     * psdm_pkg::SPEED_DEN_K;
                    end
                    psdm_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data[psdm_pkg::TMO_W-1:0];
                    psdm_pkg::CFG_MIN:     min_reg     <= cfg_data[psdm_pkg::PER_W-1:0];
                    psdm_pkg::CFG_MAX:     max_reg     <= cfg_data[psdm_pkg::PER_W-1:0];
                    default: ;
                endcase
            end
            seen_reg  <= seen_next;
            last_reg  <= last_next;
            isum_reg  <= isum_next;
            icnt_reg  <= icnt_next;
            pend_reg  <= pend_next;
            if (cmd.ring_push)
                ring_reg[ridx_reg] <= period;
            ridx_reg  <= ridx_next;
            rfull_reg <= rfull_next;
            rsum_reg  <= rsum_next;
            dpul_reg  <= dpul_next;
            speed_reg <= speed_next;
            pull_reg  <= pull_next;
            drv_reg   <= drv_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg <= in_kind;
            ts_reg   <= in_ts;
            nps_reg  <= in_pull;
        end
        if (cmd.tick_take)
        begin
            snap_pend_reg <= pend_reg;
            snap_sum_reg  <= isum_reg;
            snap_cnt_reg  <= icnt_reg;
        end
        if (cmd.mul_load)
            mul_reg <= psdm_pkg::DIV_W'(cal22_reg) * psdm_pkg::DIV_W'(rsum_reg);
        if (cmd.dist_load)
            distq_reg <= (div_quot > psdm_pkg::DIV_W'({psdm_pkg::DIST_W{1'b1}})) ? '1
                         : div_quot[psdm_pkg::DIST_W-1:0];
        if (cmd.dist_special)
            distq_reg <= (dpul_reg != '0) ? '1 : '0;
        if (cmd.emit)
        begin
            ok_kind_reg <= cmd.rep_kind;
            o_tot_reg   <= dpul_reg;
            o_speed_reg <= '0;
            o_dist_reg  <= '0;
            o_ok_reg    <= 1'b0;
            case (cmd.rep_kind)
                psdm_pkg::REP_UPDATE:
                begin
                    o_speed_reg <= speed_reg;
                    o_dist_reg  <= distq_reg;
                end
                psdm_pkg::REP_CAPTURE:
                    o_ok_reg <= (dpul_reg >= psdm_pkg::CAP_LO) && (dpul_reg <= psdm_pkg::CAP_HI);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        status.kind        = kind_reg;
        status.pulses_zero = (snap_pend_reg == '0);
        status.range_ok    = (snap_cnt_reg != '0) && (cal_reg != '0) &&
                             (snap_sum_reg > lo_lim) && (snap_sum_reg < hi_lim);
        status.drive_off   = drv_reg;
        status.pull_active = (pull_reg == psdm_pkg::PULL_STAGED) ||
                             (pull_reg == psdm_pkg::PULL_PULLING);
        status.staged      = (pull_reg == psdm_pkg::PULL_STAGED);
        status.timeout_hit = seen_reg && (elapsed > timeout_reg) &&
                             (speed_reg >= psdm_pkg::SPEED_MIN_DECAY);
        status.cal_zero    = (cal_reg == '0);
        status.div_done    = div_done;
        status.out_free    = !ov_reg || out_ready;
    end

    assign out_valid = ov_reg;
    assign out_kind  = ok_kind_reg;
    assign out_speed = o_speed_reg;
    assign out_dist  = o_dist_reg;
    assign out_total = o_tot_reg;
    assign out_ok    = o_ok_reg;

    a_ridx_range: assert property (@(posedge clk) disable iff (!rst_n)
        ridx_reg <= psdm_pkg::RIDX_W'(RD - 1))
        else $error("ring index out of range");

    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(rfull_reg))
        else $error("ring full flag cleared");

    a_push_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ring_push |=> (rsum_reg != '0))
        else $error("ring sum zero after a push");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

endmodule

@@ sv/psdm_ctrl.sv @@
// controller state machine sequencing event handling and the shared divider
// depends on psdm_pkg
module psdm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  psdm_pkg::status_t status,
    output psdm_pkg::cmd_t    cmd
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TICK,
        S_DIV_PER,
        S_MUL,
        S_SPD_GO,
        S_DIV_SPD,
        S_CLR,
        S_DIST,
        S_DIST_WAIT,
        S_EMIT
    } state_t;

    state_t                         state_reg, state_next;
    logic [psdm_pkg::RKIND_W-1:0]   rk_reg, rk_next;

    always_comb
    begin
        state_next   = state_reg;
        rk_next      = rk_reg;
        cmd          = '0;
        cmd.rep_kind = rk_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch = in_valid;
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                case (status.kind)
                    psdm_pkg::KIND_PULSE:
                    begin
                        cmd.pulse_upd = 1'b1;
                        state_next    = S_IDLE;
                    end
                    psdm_pkg::KIND_TICK:
                    begin
                        cmd.tick_take = 1'b1;
                        state_next    = S_TICK;
                    end
                    psdm_pkg::KIND_PULL:
                    begin
                        cmd.pull_upd = 1'b1;
                        state_next   = S_IDLE;
                    end
                    psdm_pkg::KIND_DRV_START:
                    begin
                        cmd.drv_start = 1'b1;
                        rk_next       = psdm_pkg::REP_COUNT;
                        state_next    = S_EMIT;
                    end
                    psdm_pkg::KIND_DRV_STOP:
                    begin
                        cmd.drv_stop = 1'b1;
                        rk_next      = psdm_pkg::REP_CAPTURE;
                        state_next   = S_EMIT;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_TICK:
            begin
                rk_next = psdm_pkg::REP_UPDATE;
                if (status.drive_off)
                begin
                    rk_next = psdm_pkg::REP_COUNT;
                    if (status.pulses_zero)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.dist_add = 1'b1;
                        state_next   = S_EMIT;
                    end
                end
                else if (status.pull_active && !status.pulses_zero)
                begin
                    cmd.dist_add = 1'b1;
                    if (status.range_ok)
                    begin
                        cmd.div_period = 1'b1;
                        state_next     = S_DIV_PER;
                    end
                    else
                        state_next = S_CLR;
                end
                else if (status.timeout_hit)
                begin
                    cmd.speed_zero = 1'b1;
                    state_next     = S_DIST;
                end
                else
                    state_next = S_IDLE;
            end
            S_DIV_PER:
            begin
                if (status.div_done)
                begin
                    cmd.ring_push = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_SPD_GO;
            end
            S_SPD_GO:
            begin
                cmd.div_speed = 1'b1;
                state_next    = S_DIV_SPD;
            end
            S_DIV_SPD:
            begin
                if (status.div_done)
                begin
                    cmd.speed_load = 1'b1;
                    state_next     = S_CLR;
                end
            end
            S_CLR:
            begin
                // staged count is cleared after the pulses were taken
                cmd.stage_clear = status.staged;
                state_next      = S_DIST;
            end
            S_DIST:
            begin
                if (status.cal_zero)
                begin
                    cmd.dist_special = 1'b1;
                    state_next       = S_EMIT;
                end
                else
                begin
                    cmd.div_dist = 1'b1;
                    state_next   = S_DIST_WAIT;
                end
            end
            S_DIST_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.dist_load = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rk_reg    <= psdm_pkg::REP_UPDATE;
        end
        else
        begin
            state_reg <= state_next;
            rk_reg    <= rk_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

@@ sv/pulse_speed_distance_meter.sv @@
// top level of the pulse speed/distance meter: controller, datapath and channel glue
// depends on psdm_pkg, psdm_if, psdm_ctrl, psdm_dp
//
//   channel   dir   handshake      payload
//   evt       in    valid/ready    kind, timestamp_us, new_pull_state
//   rpt       out   valid/ready    report_kind, speed_mph_q8, distance_ft_q8, pulse_total,
//                                  capture_ok
//   cfg       in    cfg_we only    cfg_index, cfg_data
//
// pulse and pull-state events finish in the decode state; drive-off start/stop also pass through the emit state
// a tick runs up to three passes of the shared divider (period mean, speed, distance),
// each waited out to its done strobe
// rst_n clears the controller, configuration and measurement state at once; no clearing pass is needed
// a finished report waits in the output register; a report-making event stalls in its
// last cycle while that register is held, and evt is refused while one is being built
module pulse_speed_distance_meter (
    input  logic                            clk,
    input  logic                            rst_n,
    psdm_evt_if.sink                        evt,
    psdm_rpt_if.source                      rpt,
    input  logic                            cfg_we,
    input  logic [psdm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psdm_pkg::CFG_DATA_W-1:0] cfg_data
);
    psdm_pkg::cmd_t    cmd;
    psdm_pkg::status_t status;

    psdm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (evt.valid),
        .in_ready (evt.ready),
        .status   (status),
        .cmd      (cmd)
    );

    psdm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_kind   (evt.kind),
        .in_ts     (evt.timestamp_us),
        .in_pull   (evt.new_pull_state),
        .out_valid (rpt.valid),
        .out_ready (rpt.ready),
        .out_kind  (rpt.report_kind),
        .out_speed (rpt.speed_mph_q8),
        .out_dist  (rpt.distance_ft_q8),
        .out_total (rpt.pulse_total),
        .out_ok    (rpt.capture_ok),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ sim/pulse_speed_distance_meter_checker.sv @@
// report checker for the pulse speed/distance meter: predicts every report from the
// accepted event beats and register writes, then compares each report beat in order
// depends on psdm_pkg and psdm_if
module pulse_speed_distance_meter_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    psdm_evt_if                             evt,
    psdm_rpt_if                             rpt,
    input  logic                            cfg_we,
    input  logic [psdm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psdm_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              errors,
    output int                              outstanding,
    output int                              reports
);
    typedef struct packed {
        logic [psdm_pkg::RKIND_W-1:0] rk;
        logic [psdm_pkg::SPD_W-1:0]   spd;
        logic [psdm_pkg::DIST_W-1:0]  feet;
        logic [psdm_pkg::TOT_W-1:0]   tot;
        logic                         ok;
    } meter_report_t;

    meter_report_t expected_reports[$];

    // register copies
    logic [psdm_pkg::CAL_W-1:0] cal;
    logic [psdm_pkg::TMO_W-1:0] timeout;
    logic [psdm_pkg::PER_W-1:0] min_iv;
    logic [psdm_pkg::PER_W-1:0] max_iv;

    // meter state
    logic                        pulse_seen;
    logic [psdm_pkg::TS_W-1:0]   last_pulse;
    longint unsigned             iv_sum;
    int unsigned                 iv_cnt;
    int unsigned                 pend;
    logic [psdm_pkg::PER_W-1:0]  periods [psdm_pkg::RING_DEPTH];
    int unsigned                 ring_pos;
    logic                        ring_full;
    int unsigned                 odo_pulses;
    logic [psdm_pkg::SPD_W-1:0]  speed;
    logic [psdm_pkg::PULL_W-1:0] pull;
    logic                        drive_off;

    function automatic logic [psdm_pkg::SPD_W-1:0] speed_from_ring();
        longint unsigned n;
        longint unsigned rsum;
        longint unsigned den;
        longint unsigned q;
        n = ring_full ? psdm_pkg::RING_DEPTH : ring_pos;
        rsum = 0;
        for (int i = 0; i < n; i++)
            rsum += periods[i];
        den = 64'd22 * cal * rsum;
        if (den == 0)
            return '1;
        q = (64'(psdm_pkg::SPEED_NUM) * n) / den;
        return (q > 64'hFFFF) ? '1 : q[psdm_pkg::SPD_W-1:0];
    endfunction

    function automatic logic [psdm_pkg::DIST_W-1:0] distance_from_count();
        longint unsigned q;
        if (cal == 0)
            return (odo_pulses != 0) ? '1 : '0;
        q = (64'(psdm_pkg::DIST_NUM) * odo_pulses) / cal;
        return (q > 64'hFFFF_FFFF) ? '1 : q[psdm_pkg::DIST_W-1:0];
    endfunction

    function automatic int unsigned add_sat24(int unsigned a, int unsigned b);
        return (a + b > 32'hFF_FFFF) ? 32'hFF_FFFF : a + b;
    endfunction

    task automatic predict_event(input logic [psdm_pkg::KIND_W-1:0] k,
                                 input logic [psdm_pkg::TS_W-1:0] now,
                                 input logic [psdm_pkg::PULL_W-1:0] nps);
        meter_report_t r;
        logic [psdm_pkg::TS_W-1:0] d;
        longint unsigned s;
        longint unsigned c;
        int unsigned p;
        r = '0;
        case (k)
            psdm_pkg::KIND_PULSE:
            begin
                if (pulse_seen)
                begin
                    d = now - last_pulse;
                    if (d >= min_iv && d <= max_iv && iv_cnt < 65535)
                    begin
                        iv_sum += d;
                        iv_cnt++;
                    end
                end
                last_pulse = now;
                pulse_seen = 1'b1;
                if (pend < 65535)
                    pend++;
            end
            psdm_pkg::KIND_TICK:
            begin
                p = pend;
                s = iv_sum;
                c = iv_cnt;
                pend = 0;
                iv_sum = 0;
                iv_cnt = 0;
                if (drive_off)
                begin
                    if (p != 0)
                    begin
                        odo_pulses = add_sat24(odo_pulses, p);
                        r.rk = psdm_pkg::REP_COUNT;
                        r.tot = odo_pulses[psdm_pkg::TOT_W-1:0];
                        expected_reports.push_back(r);
                    end
                end
                else if ((pull == psdm_pkg::PULL_PULLING || pull == psdm_pkg::PULL_STAGED)
                         && p > 0)
                begin
                    odo_pulses = add_sat24(odo_pulses, p);
                    if (c > 0 && cal > 0 && s > 100 * c && s < 2000000 * c)
                    begin
                        periods[ring_pos] = psdm_pkg::PER_W'(s / c);
                        ring_pos++;
                        if (ring_pos >= psdm_pkg::RING_DEPTH)
                        begin
                            ring_pos = 0;
                            ring_full = 1'b1;
                        end
                        speed = speed_from_ring();
                    end
                    if (pull == psdm_pkg::PULL_STAGED)
                        odo_pulses = 0;
                    r.rk = psdm_pkg::REP_UPDATE;
                    r.spd = speed;
                    r.feet = distance_from_count();
                    r.tot = odo_pulses[psdm_pkg::TOT_W-1:0];
                    expected_reports.push_back(r);
                end
                else if (pulse_seen && psdm_pkg::TS_W'(now - last_pulse) > timeout
                         && speed >= psdm_pkg::SPEED_MIN_DECAY)
                begin
                    speed = '0;
                    r.rk = psdm_pkg::REP_UPDATE;
                    r.feet = distance_from_count();
                    r.tot = odo_pulses[psdm_pkg::TOT_W-1:0];
                    expected_reports.push_back(r);
                end
            end
            psdm_pkg::KIND_PULL:
            begin
                pull = nps;
                if (nps == psdm_pkg::PULL_STAGED)
                    odo_pulses = 0;
            end
            psdm_pkg::KIND_DRV_START:
            begin
                drive_off = 1'b1;
                odo_pulses = 0;
                r.rk = psdm_pkg::REP_COUNT;
                expected_reports.push_back(r);
            end
            psdm_pkg::KIND_DRV_STOP:
            begin
                drive_off = 1'b0;
                r.rk = psdm_pkg::REP_CAPTURE;
                r.tot = odo_pulses[psdm_pkg::TOT_W-1:0];
                r.ok = (odo_pulses >= psdm_pkg::CAP_LO && odo_pulses <= psdm_pkg::CAP_HI);
                expected_reports.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic check_report();
        meter_report_t w;
        reports++;
        if (expected_reports.size() == 0)
        begin
            report_mismatch("unexpected report, kind", rpt.report_kind, 0);
            return;
        end
        w = expected_reports.pop_front();
        if (rpt.report_kind !== w.rk)
            report_mismatch("report_kind", rpt.report_kind, w.rk);
        if (rpt.speed_mph_q8 !== w.spd)
            report_mismatch("speed_mph_q8", rpt.speed_mph_q8, w.spd);
        if (rpt.distance_ft_q8 !== w.feet)
            report_mismatch("distance_ft_q8", rpt.distance_ft_q8, w.feet);
        if (rpt.pulse_total !== w.tot)
            report_mismatch("pulse_total", rpt.pulse_total, w.tot);
        if (rpt.capture_ok !== w.ok)
            report_mismatch("capture_ok", rpt.capture_ok, w.ok);
    endtask

    initial
    begin
        errors = 0;
        reports = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal = psdm_pkg::CAL_RST;
            timeout = psdm_pkg::TIMEOUT_RST;
            min_iv = psdm_pkg::MIN_RST;
            max_iv = psdm_pkg::MAX_RST;
            pulse_seen = 1'b0;
            last_pulse = '0;
            iv_sum = 0;
            iv_cnt = 0;
            pend = 0;
            for (int i = 0; i < psdm_pkg::RING_DEPTH; i++)
                periods[i] = '0;
            ring_pos = 0;
            ring_full = 1'b0;
            odo_pulses = 0;
            speed = '0;
            pull = psdm_pkg::PULL_READY;
            drive_off = 1'b0;
            expected_reports.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rpt.valid && rpt.ready)
                check_report();
            if (cfg_we)
            begin
                case (cfg_index)
                    psdm_pkg::CFG_CAL:     cal = cfg_data[psdm_pkg::CAL_W-1:0];
                    psdm_pkg::CFG_TIMEOUT: timeout = cfg_data[psdm_pkg::TMO_W-1:0];
                    psdm_pkg::CFG_MIN:     min_iv = cfg_data[psdm_pkg::PER_W-1:0];
                    psdm_pkg::CFG_MAX:     max_iv = cfg_data[psdm_pkg::PER_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (evt.valid && evt.ready)
                predict_event(evt.kind, evt.timestamp_us, evt.new_pull_state);
            outstanding <= expected_reports.size();
        end
    end
endmodule

@@ sim/pulse_speed_distance_meter_test.sv @@
// testbench top for the pulse speed/distance meter: clock, reset, register phases,
// directed and random event beats, random report back-pressure and the verdict
// depends on psdm_pkg, psdm_if, the block and pulse_speed_distance_meter_checker
module pulse_speed_distance_meter_test;
    localparam logic [psdm_pkg::KIND_W-1:0] KIND_SPARE_A = 3'd5;
    localparam logic [psdm_pkg::KIND_W-1:0] KIND_SPARE_B = 3'd6;
    localparam logic [psdm_pkg::KIND_W-1:0] KIND_SPARE_C = 3'd7;
    localparam logic [psdm_pkg::PULL_W-1:0] PULL_OTHER   = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [psdm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [psdm_pkg::CFG_DATA_W-1:0] cfg_data;
    int errors;
    int outstanding;
    int reports;
    int beats_sent;
    logic no_gaps;
    logic [psdm_pkg::TS_W-1:0] now_us;

    psdm_evt_if evt ();
    psdm_rpt_if rpt ();

    pulse_speed_distance_meter dut (
        .clk(clk), .rst_n(rst_n), .evt(evt), .rpt(rpt),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pulse_speed_distance_meter_checker meter_checker (
        .clk(clk), .rst_n(rst_n), .evt(evt), .rpt(rpt),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .outstanding(outstanding), .reports(reports)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        evt.valid = 1'b0;
        evt.kind = '0;
        evt.timestamp_us = '0;
        evt.new_pull_state = '0;
        rpt.ready = 1'b0;
        no_gaps = 1'b0;
        beats_sent = 0;
        now_us = '0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [psdm_pkg::PULL_W-1:0] rand_pull();
        return psdm_pkg::PULL_W'($urandom_range(0, 3));
    endfunction

    // report back-pressure: mostly short stalls, now and then a long one
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            rpt.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            rpt.ready <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(20, 60)) @(posedge clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    end

    task automatic send(input logic [psdm_pkg::KIND_W-1:0] k,
                        input logic [psdm_pkg::TS_W-1:0] ts,
                        input logic [psdm_pkg::PULL_W-1:0] nps);
        int g;
        logic hs;
        g = no_gaps ? 0 : gap_len();
        if (g > 0)
        begin
            evt.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        evt.valid <= 1'b1;
        evt.kind <= k;
        evt.timestamp_us <= ts;
        evt.new_pull_state <= nps;
        do
        begin
            @(negedge clk);
            hs = evt.ready;
            @(posedge clk);
        end
        while (!hs);
        beats_sent++;
    endtask

    task automatic pulse_after(input logic [psdm_pkg::TS_W-1:0] step);
        now_us += step;
        send(psdm_pkg::KIND_PULSE, now_us, rand_pull());
    endtask

    task automatic tick_after(input logic [psdm_pkg::TS_W-1:0] step);
        now_us += step;
        send(psdm_pkg::KIND_TICK, now_us, rand_pull());
    endtask

    task automatic pull_to(input logic [psdm_pkg::PULL_W-1:0] st);
        send(psdm_pkg::KIND_PULL, now_us, st);
    endtask

    function automatic logic [psdm_pkg::TS_W-1:0] rand_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(100, 30000);
        if (r < 90)
            return $urandom_range(1, 99);
        if (r < 95)
            return $urandom_range(2000001, 3000000);
        return $urandom_range(30000, 2000000);
    endfunction

    // drain: block idle before a register change or the verdict
    task automatic settle();
        evt.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic set_registers(input logic [31:0] c, input logic [31:0] t,
                                 input logic [31:0] mn, input logic [31:0] mx);
        cfg_we <= 1'b1;
        cfg_index <= psdm_pkg::CFG_CAL;
        cfg_data <= c;
        @(posedge clk);
        cfg_index <= psdm_pkg::CFG_TIMEOUT;
        cfg_data <= t;
        @(posedge clk);
        cfg_index <= psdm_pkg::CFG_MIN;
        cfg_data <= mn;
        @(posedge clk);
        cfg_index <= psdm_pkg::CFG_MAX;
        cfg_data <= mx;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_events(input int count);
        int stop_at;
        int r;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                pull_to(($urandom_range(0, 4) == 0) ? psdm_pkg::PULL_STAGED
                                                     : psdm_pkg::PULL_PULLING);
                repeat ($urandom_range(1, 6))
                begin
                    repeat ($urandom_range(0, 6)) pulse_after(rand_interval());
                    tick_after($urandom_range(0, 50000));
                end
            end
            else if (r < 68)
            begin
                send(psdm_pkg::KIND_DRV_START, now_us, rand_pull());
                repeat ($urandom_range(0, 4))
                begin
                    repeat ($urandom_range(0, 5)) pulse_after(rand_interval());
                    tick_after($urandom_range(0, 50000));
                end
                send(psdm_pkg::KIND_DRV_STOP, now_us, rand_pull());
            end
            else if (r < 80)
            begin
                // long silence after some motion, so the speed decays
                pull_to(psdm_pkg::PULL_PULLING);
                repeat ($urandom_range(2, 5)) pulse_after($urandom_range(100, 5000));
                tick_after(1000);
                pull_to(psdm_pkg::PULL_READY);
                tick_after($urandom);
            end
            else if (r < 90)
                pull_to(rand_pull());
            else
            begin
                now_us = $urandom;
                send(psdm_pkg::KIND_W'($urandom_range(0, 7)), now_us, rand_pull());
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first pulse, interval bounds, decay, drive-off, spare kinds, wrap
        pull_to(psdm_pkg::PULL_STAGED);
        pull_to(psdm_pkg::PULL_PULLING);
        now_us = '0;
        send(psdm_pkg::KIND_PULSE, now_us, PULL_OTHER);
        pulse_after(100);
        pulse_after(2000000);
        pulse_after(99);
        pulse_after(2000001);
        tick_after(10);
        tick_after(32'd5000000);
        send(psdm_pkg::KIND_DRV_STOP, now_us, psdm_pkg::PULL_READY);
        send(psdm_pkg::KIND_DRV_START, now_us, psdm_pkg::PULL_READY);
        tick_after(5);
        pulse_after(300);
        tick_after(5);
        send(psdm_pkg::KIND_DRV_STOP, now_us, psdm_pkg::PULL_READY);
        send(KIND_SPARE_A, 32'hFFFF_FFFF, PULL_OTHER);
        send(KIND_SPARE_B, now_us, psdm_pkg::PULL_READY);
        send(KIND_SPARE_C, now_us, psdm_pkg::PULL_READY);
        pull_to(PULL_OTHER);
        now_us = 32'hFFFF_FFF0;
        send(psdm_pkg::KIND_PULSE, now_us, psdm_pkg::PULL_READY);
        pulse_after(32'h200);
        pull_to(psdm_pkg::PULL_PULLING);
        tick_after(1);
        pull_to(psdm_pkg::PULL_READY);
        random_events(50);
        settle();

        set_registers(250, 1, 1, 2000000);
        random_events(50);
        settle();
        set_registers(25000, 32'hFFFF_FFFF, 2000000, 2000000);
        random_events(40);
        settle();
        set_registers(0, 1000000, 100, 2000000);
        random_events(40);
        settle();
        set_registers(32767, 5000, 200, 50000);
        random_events(50);
        settle();
        set_registers(1000, 2000, 40000, 300);
        random_events(25);
        settle();

        // back-to-back beats with no idle gaps
        set_registers($urandom_range(250, 25000), $urandom_range(1, 3000000),
                      $urandom_range(1, 500), 32'h1F_FFFF);
        no_gaps = 1'b1;
        random_events(50);
        no_gaps = 1'b0;
        settle();

        $display("covered %0d event beats over 7 register settings, %0d reports checked",
                 beats_sent, reports);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("timeout with %0d reports still due", outstanding);
        $display("FAILED: results differ");
        $finish;
    end
endmodule
